// ===== hw/rtl/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared widths and constants of the gated cosine similarity block.
// ----------------------------------------------------------------------------
package gcs_pkg;

  parameter int ELEM_BITS_DEF = 16;

  // accumulator widths, all sums in q.28
  parameter int DIFF_W = 42;
  parameter int DOT_W  = 41;
  parameter int NORM_W = 40;

  // final evaluation datapath
  parameter int MAG_W  = DOT_W;           // magnitude of the dot sum
  parameter int PROD_W = 2 * NORM_W;      // product of the two norms
  parameter int ALU_W  = 2 * MAG_W;       // shared add/subtract unit
  parameter int QUO_W  = 28;              // fractional quotient bits
  parameter int ROOT_W = QUO_W / 2;
  parameter int SREM_W = ROOT_W + 2;
  parameter int SIM_W  = 16;
  parameter int CNT_W  = 6;

  parameter logic [DIFF_W-1:0] LIMIT_RESET = DIFF_W'(64'd268435456);
  parameter logic [SIM_W-1:0]  SIM_ONE     = SIM_W'(16384);

endpackage

// ===== hw/rtl/gated_cosine_similarity_top.sv =====
// ----------------------------------------------------------------------------
// gated_cosine_similarity_top
// Gated cosine similarity of a streamed query and reference vector.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one element pair per transfer; tlast marks the final pair.
//   Pairs are accumulated at one transfer per cycle into four saturating sums.
//   After the final pair the block drops tready and evaluates the result with
//   one shared add/subtract unit under a small sequencer:
//     gate closed or zero norm : result straight from the check
//     magnitude clamped to 1.0 : result after both multiplies and the compare
//     full evaluation          : 41 + 41 shift-add multiply steps,
//                                28 restoring divide steps, 14 root steps
//   m_axis carries one result per vector. The result sits in an output
//   register; once it is loaded the block accepts the next vector even while
//   the receiver stalls. A second result waits in the sequencer until the
//   output register frees up.
//   cfg_we_i writes the squared distance limit (q.28); write only when idle.
//   Reset clears the sums, the sequencer and the output valid, and sets the
//   limit to 1.0.
// ----------------------------------------------------------------------------
module gated_cosine_similarity_top #(
  parameter int ELEM_BITS = gcs_pkg::ELEM_BITS_DEF,
  localparam int S_TDATA_W = ((2 * ELEM_BITS + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gcs_pkg::DIFF_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // query_element, reference_element
  input  logic [S_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // similarity
  output logic [gcs_pkg::SIM_W-1:0] m_axis_tdata_o,
  // gated_out, zero_norm
  output logic [1:0]                m_axis_tuser_o
);
  import gcs_pkg::*;

  localparam int PW = 2 * ELEM_BITS;
  localparam int UW = ((PW + 2 > DIFF_W) ? PW + 2 : DIFF_W) + 1;
  localparam int NW = ((PW > NORM_W) ? PW : NORM_W) + 1;
  localparam int DW = ((PW > DOT_W) ? PW : DOT_W) + 2;

  localparam logic [UW-1:0] DIFF_MAX = {{(UW - DIFF_W){1'b0}}, {DIFF_W{1'b1}}};
  localparam logic [NW-1:0] NORM_MAX = {{(NW - NORM_W){1'b0}}, {NORM_W{1'b1}}};
  localparam logic signed [DW-1:0] DOT_HI = {{(DW - DOT_W + 1){1'b0}}, {(DOT_W - 1){1'b1}}};
  localparam logic signed [DW-1:0] DOT_LO = ~DOT_HI;

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MULP  = 3'd2;
  localparam logic [2:0] ST_MULM  = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SQRT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(QUO_W - 1);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ROOT_W - 1);

  // input stage
  logic signed [ELEM_BITS-1:0] q_q, r_q;
  logic stg_vld_q, stg_last_q;
  logic s_fire;

  // sums
  logic [DIFF_W-1:0] limit_q;
  logic [DIFF_W-1:0] diff_sum_q, diff_sum_d;
  logic [DOT_W-1:0]  dot_sum_q, dot_sum_d;
  logic [NORM_W-1:0] qn_sum_q, qn_sum_d, rn_sum_q, rn_sum_d;

  // sequencer and datapath
  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ALU_W-1:0]  pr_q, pr_d;
  logic [MAG_W-1:0]  mcand_q, mcand_d;
  logic [PROD_W-1:0] p_q, p_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [SREM_W-1:0] srem_q, srem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic              neg_q, neg_d;
  logic [SIM_W-1:0]  res_sim_q, res_sim_d;
  logic              res_gate_q, res_gate_d, res_zero_q, res_zero_d;
  logic              clear_sums;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [SIM_W-1:0]  m_sim_q, m_sim_d;
  logic              m_gate_q, m_gate_d, m_zero_q, m_zero_d;

  // shared add/subtract unit
  logic [ALU_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [ALU_W:0]   alu_y;
  logic             alu_ge;

  assign s_axis_tready_o = (state_q == ST_ACC) && !(stg_vld_q && stg_last_q);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      q_q        <= s_axis_tdata_i[ELEM_BITS-1:0];
      r_q        <= s_axis_tdata_i[2*ELEM_BITS-1:ELEM_BITS];
      stg_last_q <= s_axis_tlast_i;
    end
  end

  // per-pair products and saturating accumulation
  logic signed [ELEM_BITS:0]   dif;
  logic signed [PW+1:0]        dsq;
  logic signed [PW-1:0]        qsq, rsq, qr;
  logic [UW-1:0]               diff_ext;
  logic [NW-1:0]               qn_ext, rn_ext;
  logic signed [DW-1:0]        dot_ext;

  always_comb begin
    dif      = {q_q[ELEM_BITS-1], q_q} - {r_q[ELEM_BITS-1], r_q};
    dsq      = dif * dif;
    qsq      = q_q * q_q;
    rsq      = r_q * r_q;
    qr       = q_q * r_q;
    diff_ext = UW'(diff_sum_q) + UW'($unsigned(dsq));
    qn_ext   = NW'(qn_sum_q) + NW'($unsigned(qsq));
    rn_ext   = NW'(rn_sum_q) + NW'($unsigned(rsq));
    dot_ext  = DW'($signed(dot_sum_q)) + DW'(qr);

    diff_sum_d = diff_sum_q;
    qn_sum_d   = qn_sum_q;
    rn_sum_d   = rn_sum_q;
    dot_sum_d  = dot_sum_q;
    if (clear_sums) begin
      diff_sum_d = '0;
      qn_sum_d   = '0;
      rn_sum_d   = '0;
      dot_sum_d  = '0;
    end else if (stg_vld_q) begin
      diff_sum_d = (diff_ext > DIFF_MAX) ? DIFF_MAX[DIFF_W-1:0] : diff_ext[DIFF_W-1:0];
      qn_sum_d   = (qn_ext > NORM_MAX) ? NORM_MAX[NORM_W-1:0] : qn_ext[NORM_W-1:0];
      rn_sum_d   = (rn_ext > NORM_MAX) ? NORM_MAX[NORM_W-1:0] : rn_ext[NORM_W-1:0];
      if (dot_ext > DOT_HI) begin
        dot_sum_d = DOT_HI[DOT_W-1:0];
      end else if (dot_ext < DOT_LO) begin
        dot_sum_d = DOT_LO[DOT_W-1:0];
      end else begin
        dot_sum_d = dot_ext[DOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LIMIT_RESET;
      diff_sum_q <= '0;
      dot_sum_q  <= '0;
      qn_sum_q   <= '0;
      rn_sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      diff_sum_q <= diff_sum_d;
      dot_sum_q  <= dot_sum_d;
      qn_sum_q   <= qn_sum_d;
      rn_sum_q   <= rn_sum_d;
    end
  end

  // shared unit operand selection
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_MULP, ST_MULM: begin
        alu_a = ALU_W'(pr_q[ALU_W-1:MAG_W]);
        alu_b = pr_q[0] ? ALU_W'(mcand_q) : '0;
      end
      ST_CMP: begin
        alu_a   = pr_q;
        alu_b   = ALU_W'(p_q);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {pr_q[ALU_W-2:0], 1'b0};
        alu_b   = ALU_W'(p_q);
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = ALU_W'({srem_q, quo_q[QUO_W-1:QUO_W-2]});
        alu_b   = ALU_W'({root_q, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_y  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ALU_W + 1)'(alu_sub);
    alu_ge = alu_y[ALU_W];
  end

  // sequencer
  logic [MAG_W-1:0] mag;
  logic [SIM_W-1:0] k_mag;

  always_comb begin
    mag = dot_sum_q[DOT_W-1] ? (~dot_sum_q + MAG_W'(1)) : dot_sum_q;

    state_d    = state_q;
    cnt_d      = cnt_q;
    pr_d       = pr_q;
    mcand_d    = mcand_q;
    p_d        = p_q;
    quo_d      = quo_q;
    srem_d     = srem_q;
    root_d     = root_q;
    neg_d      = neg_q;
    res_sim_d  = res_sim_q;
    res_gate_d = res_gate_q;
    res_zero_d = res_zero_q;
    clear_sums = 1'b0;
    k_mag      = '0;

    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_sim_d   = m_sim_q;
    m_gate_d  = m_gate_q;
    m_zero_d  = m_zero_q;

    unique case (state_q)
      ST_ACC: begin
        if (stg_vld_q && stg_last_q) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_sim_d  = '0;
        res_gate_d = 1'b0;
        res_zero_d = 1'b0;
        neg_d      = dot_sum_q[DOT_W-1];
        if (diff_sum_q >= limit_q) begin
          res_gate_d = 1'b1;
          state_d    = ST_DONE;
        end else if (qn_sum_q == '0 || rn_sum_q == '0) begin
          res_zero_d = 1'b1;
          state_d    = ST_DONE;
        end else begin
          pr_d    = ALU_W'(qn_sum_q);
          mcand_d = MAG_W'(rn_sum_q);
          cnt_d   = MUL_STEPS;
          state_d = ST_MULP;
        end
      end
      ST_MULP, ST_MULM: begin
        pr_d  = {alu_y[MAG_W:0], pr_q[MAG_W-1:1]};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          if (state_q == ST_MULP) begin
            p_d     = pr_d[PROD_W-1:0];
            pr_d    = ALU_W'(mag);
            mcand_d = mag;
            cnt_d   = MUL_STEPS;
            state_d = ST_MULM;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        // quotient (squared similarity) at or above one: clamp to 1.0
        if (alu_ge) begin
          res_sim_d = neg_q ? (SIM_W'(0) - SIM_ONE) : SIM_ONE;
          state_d   = ST_DONE;
        end else begin
          cnt_d   = DIV_STEPS;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d = {quo_q[QUO_W-2:0], alu_ge};
        pr_d  = alu_ge ? alu_y[ALU_W-1:0] : alu_a;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = SQRT_STEPS;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        quo_d  = {quo_q[QUO_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], alu_ge};
        srem_d = alu_ge ? alu_y[SREM_W-1:0] : alu_a[SREM_W-1:0];
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          k_mag     = SIM_W'(root_d);
          res_sim_d = neg_q ? (SIM_W'(0) - k_mag) : k_mag;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_sim_d    = res_sim_q;
          m_gate_d   = res_gate_q;
          m_zero_d   = res_zero_q;
          clear_sums = 1'b1;
          state_d    = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACC;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q       <= pr_d;
    mcand_q    <= mcand_d;
    p_q        <= p_d;
    quo_q      <= quo_d;
    srem_q     <= srem_d;
    root_q     <= root_d;
    neg_q      <= neg_d;
    res_sim_q  <= res_sim_d;
    res_gate_q <= res_gate_d;
    res_zero_q <= res_zero_d;
    m_sim_q    <= m_sim_d;
    m_gate_q   <= m_gate_d;
    m_zero_q   <= m_zero_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_sim_q;
  assign m_axis_tuser_o  = {m_zero_q, m_gate_q};

endmodule
